### hdl/glh_pkg.sv
// ----------------------------------------------------------------------------
// glh_pkg: shared types and constants of the gas level to color converter
// Fixed-point constants, register map codes and pipeline word types.
// ----------------------------------------------------------------------------
`default_nettype none
package glh_pkg;

	localparam int unsigned HueStart  = 9600;   // 600 degrees in 1/16 degree
	localparam int unsigned HueSpan   = 4800;   // 300 degrees in 1/16 degree
	localparam int unsigned HueWrap   = 5760;   // 360 degrees in 1/16 degree
	localparam int unsigned SectorLen = 960;    // 60 degrees in 1/16 degree
	localparam int unsigned QuoBits   = 13;     // quotient never exceeds HueSpan
	localparam int unsigned RemBits   = 29;     // HueSpan * 65535 fits here
	localparam int unsigned RecipShift = 36;
	// ceil(2^36 / 960): exact floor division for products below 2^26
	localparam logic [26:0] RecipSector = 27'd71582789;

	localparam int unsigned AddrBits = 4;

	typedef enum logic [1:0] {
		REG_FULL_SCALE = 2'd0,
		REG_SAT        = 2'd1,
		REG_LIGHT      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [RemBits-1:0] rem;
		logic [QuoBits-1:0] quo;
	} div_word_t;

	function automatic logic [12:0] sector_base(input logic [2:0] sec);
		logic [12:0] b;
		case (sec)
			3'd0:    b = 13'd0;
			3'd1:    b = 13'd960;
			3'd2:    b = 13'd1920;
			3'd3:    b = 13'd2880;
			3'd4:    b = 13'd3840;
			default: b = 13'd4800;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] to_channel(input logic [16:0] v);
		logic [24:0] p;
		p = {v, 8'd0} - {8'd0, v};
		return (p[24:16] > 9'd255) ? 8'd255 : p[23:16];
	endfunction

endpackage
`default_nettype wire

### hdl/glh_if.sv
// ----------------------------------------------------------------------------
// glh channel interfaces
// Ready/valid channels for the ppm reading and the RGB color word.
// ----------------------------------------------------------------------------
`default_nettype none
interface glh_meas_if;
	logic        valid;
	logic        ready;
	logic [15:0] co2_ppm;
	modport source (output valid, output co2_ppm, input ready);
	modport sink   (input valid, input co2_ppm, output ready);
endinterface

interface glh_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

### hdl/glh_div_cell.sv
// ----------------------------------------------------------------------------
// glh_div_cell: one restoring division cell
// Tries one shifted divisor against the partial remainder, yields one bit.
// ----------------------------------------------------------------------------
`default_nettype none
module glh_div_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vin,
	input  wire glh_pkg::div_word_t         win,
	input  wire logic [glh_pkg::RemBits-1:0] dv,
	output logic                            vout,
	output glh_pkg::div_word_t              wout
);
	import glh_pkg::*;

	logic hit;
	assign hit = (win.rem >= dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wout.rem <= hit ? (win.rem - dv) : win.rem;
			wout.quo <= {win.quo[QuoBits-2:0], hit};
		end
	end
endmodule
`default_nettype wire

### hdl/glh_ramp.sv
// ----------------------------------------------------------------------------
// glh_ramp: two-stage ramp interpolator
// Computes floor(d * k / 960) with a product stage and a reciprocal stage.
// ----------------------------------------------------------------------------
`default_nettype none
module glh_ramp (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [16:0] d,
	input  wire logic [9:0]  k,
	output logic [16:0]      ramp_s2
);
	import glh_pkg::*;

	logic [26:0] prod_s1;
	logic [53:0] recip;

	assign recip = {27'd0, prod_s1} * {27'd0, RecipSector};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 27'({10'd0, d} * {17'd0, k});
			ramp_s2 <= recip[RecipShift+16:RecipShift];
		end
	end
endmodule
`default_nettype wire

### hdl/gas_level_to_hsl_color.sv
// ----------------------------------------------------------------------------
// gas_level_to_hsl_color: ppm reading to RGB color via HSL hue
// Clamps, maps the reading to a hue, converts to RGB with six sectors.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  meas     | in  | co2_ppm[15:0]
//  color    | out | red, green, blue [7:0]
//  apb      | in  | ppm_full_scale @0, sat_level @4, light_level @8
//
// One word per cycle while the output is not stalled: a product stage, 13 division
// cells (one quotient bit each), a hue stage, two ramp stages, output.
// The whole pipeline moves when the output register is empty or taken.
// arst_n clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module gas_level_to_hsl_color (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	glh_meas_if.sink                           meas,
	glh_color_if.source                        color,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [glh_pkg::AddrBits-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import glh_pkg::*;

	logic [15:0] fs_q;
	logic [7:0]  sat_q;
	logic [7:0]  light_q;
	reg_idx_t    ridx;

	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= 16'd3500;
			sat_q   <= 8'd230;
			light_q <= 8'd77;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_FULL_SCALE: fs_q    <= pwdata[15:0];
				REG_SAT:        sat_q   <= pwdata[7:0];
				REG_LIGHT:      light_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_FULL_SCALE: prdata = {16'd0, fs_q};
			REG_SAT:        prdata = {24'd0, sat_q};
			REG_LIGHT:      prdata = {24'd0, light_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Pipeline advance
	logic en;
	logic vout_q;
	assign en         = !vout_q || color.ready;
	assign meas.ready = en;

	logic [15:0] fsv;
	logic [15:0] clamp;
	assign fsv   = (fs_q == 16'd0) ? 16'd1 : fs_q;
	assign clamp = (meas.co2_ppm > fsv) ? fsv : meas.co2_ppm;

	logic      v_s1;
	div_word_t w_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= meas.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1.rem <= RemBits'({16'd0, clamp} * 32'(HueSpan));
			w_s1.quo <= '0;
		end
	end

	// Division chain, most significant quotient bit first
	logic      dvld [QuoBits+1];
	div_word_t dwrd [QuoBits+1];
	assign dvld[0] = v_s1;
	assign dwrd[0] = w_s1;

	for (genvar i = 0; i < QuoBits; i++) begin : g_div
		logic [RemBits-1:0] dv;
		assign dv = RemBits'({13'd0, fsv} << (QuoBits - 1 - i));
		glh_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (dvld[i]),
			.win    (dwrd[i]),
			.dv     (dv),
			.vout   (dvld[i+1]),
			.wout   (dwrd[i+1])
		);
	end

	// Hue, sector and offset
	logic [13:0] hraw;
	logic [12:0] hue;
	logic [2:0]  sec;
	assign hraw = 14'(HueStart) - {1'b0, dwrd[QuoBits].quo};
	assign hue  = (hraw >= 14'(HueWrap)) ? 13'(hraw - 14'(HueWrap)) : hraw[12:0];

	always_comb begin
		if (hue < 13'd960)       sec = 3'd0;
		else if (hue < 13'd1920) sec = 3'd1;
		else if (hue < 13'd2880) sec = 3'd2;
		else if (hue < 13'd3840) sec = 3'd3;
		else if (hue < 13'd4800) sec = 3'd4;
		else                     sec = 3'd5;
	end

	logic       v_h;
	logic [2:0] sec_h;
	logic [9:0] f_h;
	logic [12:0] fwide;
	assign fwide = hue - sector_base(sec);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_h <= 1'b0;
		end else if (en) begin
			v_h <= dvld[QuoBits];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sec_h <= sec;
			f_h   <= fwide[9:0];
		end
	end

	// Chroma depends only on the registers; it is refreshed every cycle.
	logic [16:0] twol;
	logic [16:0] ldev;
	logic [16:0] onem;
	logic [32:0] cprod;
	logic [15:0] half_q;
	assign twol  = {light_q, 9'd0};
	assign ldev  = (twol >= 17'h10000) ? (twol - 17'h10000) : (17'h10000 - twol);
	assign onem  = 17'h10000 - ldev;
	assign cprod = {1'b0, sat_q, 8'd0} * onem;
	always_ff @(posedge clk) begin
		half_q <= cprod[32:17];
	end

	logic [16:0] lv;
	logic [16:0] mx;
	logic [16:0] mn;
	logic [16:0] dd;
	assign lv = {1'b0, light_q, 8'd0};
	assign mx = lv + {1'b0, half_q};
	assign mn = lv - {1'b0, half_q};
	assign dd = {half_q, 1'b0};

	logic [16:0] rise_s2;
	logic [16:0] fall_s2;
	glh_ramp u_rise (.clk(clk), .en(en), .d(dd), .k(f_h), .ramp_s2(rise_s2));
	glh_ramp u_fall (
		.clk(clk), .en(en), .d(dd), .k(10'(SectorLen) - f_h), .ramp_s2(fall_s2)
	);

	logic       v_r1, v_r2;
	logic [2:0] sec_r1, sec_r2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1   <= 1'b0;
			v_r2   <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v_r1   <= v_h;
			v_r2   <= v_r1;
			vout_q <= v_r2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sec_r1 <= sec_h;
			sec_r2 <= sec_r1;
		end
	end

	logic [16:0] rv, fv, r, g, b;
	assign rv = mn + rise_s2;
	assign fv = mn + fall_s2;
	always_comb begin
		case (sec_r2)
			3'd0:    begin r = mx; g = rv; b = mn; end
			3'd1:    begin r = fv; g = mx; b = mn; end
			3'd2:    begin r = mn; g = mx; b = rv; end
			3'd3:    begin r = mn; g = fv; b = mx; end
			3'd4:    begin r = rv; g = mn; b = mx; end
			default: begin r = mx; g = mn; b = fv; end
		endcase
	end

	logic [7:0] red_q, green_q, blue_q;
	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= to_channel(r);
			green_q <= to_channel(g);
			blue_q  <= to_channel(b);
		end
	end

	assign color.valid = vout_q;
	assign color.red   = red_q;
	assign color.green = green_q;
	assign color.blue  = blue_q;
endmodule
`default_nettype wire

### hdl/glh_checker.sv
// ----------------------------------------------------------------------------
// glh_checker: port-level checks of the gas level to color converter
// Watches the channels and the register port of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module glh_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_red,
	input wire logic [7:0] out_green,
	input wire logic [7:0] out_blue,
	input wire logic       pready
);
	// The input side takes a word exactly when the output side can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the output register");

	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue))
		else $error("stalled output word changed");

	// A new word only appears in the cycle after the pipeline advanced.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("output word appeared without the pipeline moving");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("register port not ready");
endmodule

bind gas_level_to_hsl_color glh_checker u_glh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (meas.ready),
	.out_valid (color.valid),
	.out_ready (color.ready),
	.out_red   (color.red),
	.out_green (color.green),
	.out_blue  (color.blue),
	.pready    (pready)
);
`default_nettype wire

### dv/gas_level_to_hsl_color_tb.sv
// ----------------------------------------------------------------------------
// gas_level_to_hsl_color_tb: self-checking bench of the gas level to color block
// Writes the registers over APB between phases and sends directed and random
// readings with random gaps on both channels. Every color word is compared with
// a built-in prediction of the hue mapping and the six-sector conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gas_level_to_hsl_color_tb;
	import glh_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct {
		logic [15:0] ppm;
		logic        known;
		rgb_t        rgb;
	} dir_row_t;

	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned Latency   = 18;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AddrBits-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	glh_meas_if  meas();
	glh_color_if color();

	gas_level_to_hsl_color i_dut (
		.clk(clk), .arst_n(arst_n), .meas(meas.sink), .color(color.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [15:0] full_scale;
	logic [7:0]  sat, light;
	rgb_t        color_q[$];
	int          errors = 0;
	int          idle_cycles = 0;

	function automatic logic [7:0] scale_channel(input logic [31:0] v);
		logic [39:0] c;
		c = ({8'd0, v} * 40'd255) >> 16;
		return (c > 40'd255) ? 8'd255 : c[7:0];
	endfunction

	function automatic rgb_t predict_color(input logic [15:0] ppm);
		logic [31:0] fs, c, h, sector, f, s, l, twol, ldev, chroma, half, mx, mn, d;
		logic [31:0] rise, fall, r, g, b;
		logic [63:0] prod;
		rgb_t o;
		fs = (full_scale == 0) ? 32'd1 : {16'd0, full_scale};
		c = (ppm > fs) ? fs : {16'd0, ppm};
		h = HueStart - (HueSpan * c) / fs;
		if (h >= HueWrap)
			h = h - HueWrap;
		sector = h / SectorLen;
		f = h - sector * SectorLen;
		s = {16'd0, sat, 8'd0};
		l = {16'd0, light, 8'd0};
		twol = 2 * l;
		ldev = (twol >= 32'd65536) ? twol - 32'd65536 : 32'd65536 - twol;
		prod = {32'd0, s} * {32'd0, 32'd65536 - ldev};
		chroma = prod[47:16];
		half = chroma >> 1;
		mx = l + half;
		mn = l - half;
		d = mx - mn;
		rise = mn + (d * f) / SectorLen;
		fall = mn + (d * (SectorLen - f)) / SectorLen;
		case (sector)
			0: begin r = mx; g = rise; b = mn; end
			1: begin r = fall; g = mx; b = mn; end
			2: begin r = mn; g = mx; b = rise; end
			3: begin r = mn; g = fall; b = mx; end
			4: begin r = rise; g = mn; b = mx; end
			default: begin r = mx; g = mn; b = fall; end
		endcase
		o.red = scale_channel(r);
		o.green = scale_channel(g);
		o.blue = scale_channel(b);
		return o;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= AddrBits'(4 * int'(idx)); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_FULL_SCALE: full_scale = val[15:0];
			REG_SAT:        sat = val[7:0];
			default:        light = val[7:0];
		endcase
	endtask

	// Valid stays high across a zero gap, so words can go back to back.
	task automatic send_reading(input logic [15:0] ppm, input logic known, input rgb_t rgb);
		int gap;
		rgb_t want;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			meas.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		meas.valid <= 1'b1;
		meas.co2_ppm <= ppm;
		do @(posedge clk); while (!meas.ready);
		want = predict_color(ppm);
		if (known && want !== rgb) begin
			$display("%0t: table entry for ppm %0d disagrees: expected %h, predicted %h",
				$time, ppm, rgb, want);
			errors++;
		end
		color_q.push_back(want);
	endtask

	task automatic drain;
		meas.valid <= 1'b0;
		while (color_q.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int n, input logic [15:0] fs_now);
		logic [15:0] v;
		repeat (n) begin
			case ($urandom_range(0, 4))
				0: v = 16'($urandom_range(0, 65535));
				1: v = fs_now;
				default: v = 16'($urandom_range(0, fs_now));
			endcase
			send_reading(v, 1'b0, '0);
		end
	endtask

	// Color sink: random stall per word, checks against the oldest prediction.
	initial begin
		int stall;
		rgb_t want;
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				color.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			color.ready <= 1'b1;
			do @(posedge clk); while (!color.valid);
			if (color_q.size() == 0) begin
				$display("%0t: color word %h%h%h with none expected", $time,
					color.red, color.green, color.blue);
				errors++;
			end else begin
				want = color_q.pop_front();
				if (color.red !== want.red)
					$display("%0t: red expected %0d, got %0d", $time, want.red, color.red);
				if (color.green !== want.green)
					$display("%0t: green expected %0d, got %0d", $time, want.green,
						color.green);
				if (color.blue !== want.blue)
					$display("%0t: blue expected %0d, got %0d", $time, want.blue,
						color.blue);
				if ({color.red, color.green, color.blue} !== want)
					errors++;
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel and no register access.
	always @(posedge clk) begin
		if ((meas.valid && meas.ready) || (color.valid && color.ready) || psel)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	dir_row_t dir_rows[12] = '{
		'{16'd0,     1'b0, '0},
		'{16'd1,     1'b0, '0},
		'{16'd874,   1'b0, '0},
		'{16'd875,   1'b0, '0},
		'{16'd1750,  1'b0, '0},
		'{16'd2625,  1'b0, '0},
		'{16'd3499,  1'b0, '0},
		'{16'd3500,  1'b0, '0},
		'{16'd3501,  1'b0, '0},
		'{16'd65535, 1'b0, '0},
		'{16'hAAAA,  1'b0, '0},
		'{16'h5555,  1'b0, '0}
	};

	logic [15:0] fs_set[8] = '{16'd1, 16'd2, 16'd960, 16'd3500, 16'd4800,
		16'd65535, 16'hFFFF, 16'd12345};

	initial begin
		meas.valid = 1'b0;
		meas.co2_ppm = '0;
		full_scale = 16'd3500;
		sat = 8'd230;
		light = 8'd77;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_reading(dir_rows[i].ppm, dir_rows[i].known, dir_rows[i].rgb);
		drain();

		// Gray with zero saturation and the black and white extremes of lightness.
		write_reg(REG_SAT, 32'd0);
		send_reading(16'd0, 1'b1, '{8'd76, 8'd76, 8'd76});
		drain();
		write_reg(REG_SAT, 32'd255);
		write_reg(REG_LIGHT, 32'd0);
		send_reading(16'd1000, 1'b1, '{8'd0, 8'd0, 8'd0});
		drain();
		write_reg(REG_LIGHT, 32'd255);
		send_reading(16'd65535, 1'b1, '{8'd254, 8'd253, 8'd254});
		drain();
		write_reg(REG_LIGHT, 32'd128);
		send_reading(16'd0, 1'b0, '0);
		send_reading(16'd3500, 1'b0, '0);
		drain();
		// Zero full scale behaves as one; upper bits of the data are ignored.
		write_reg(REG_FULL_SCALE, 32'hFFFF_0000);
		send_reading(16'd0, 1'b0, '0);
		send_reading(16'd1, 1'b0, '0);
		send_reading(16'd65535, 1'b0, '0);
		drain();

		foreach (fs_set[k]) begin
			write_reg(REG_FULL_SCALE, {16'($urandom_range(0, 65535)), fs_set[k]});
			write_reg(REG_SAT, (k % 3 == 0) ? 32'hFFFF_FF00 :
				(k % 3 == 1) ? 32'h0000_00FF : $urandom);
			write_reg(REG_LIGHT, (k % 4 == 0) ? 32'h0 : (k % 4 == 1) ? 32'hFF :
				$urandom);
			run_random(200, fs_set[k]);
			drain();
			repeat (Latency + 2) @(posedge clk);
		end

		drain();
		repeat (Latency + 4) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
